>>> src/ofcw_pkg.sv
`default_nettype none
package ofcw_pkg;
    localparam int unsigned WHEEL_SIZE = 55;
    localparam int unsigned CORDIC_STEPS = 16;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] a;
        begin
            case (i)
                4'd0: a = 32'h20000000;
                4'd1: a = 32'h12E4051E;
                4'd2: a = 32'h09FB385B;
                4'd3: a = 32'h051111D4;
                4'd4: a = 32'h028B0D43;
                4'd5: a = 32'h0145D7E1;
                4'd6: a = 32'h00A2F61E;
                4'd7: a = 32'h00517C55;
                4'd8: a = 32'h0028BE53;
                4'd9: a = 32'h00145F2F;
                4'd10: a = 32'h000A2F98;
                4'd11: a = 32'h000517CC;
                4'd12: a = 32'h00028BE6;
                4'd13: a = 32'h000145F3;
                4'd14: a = 32'h0000A2FA;
                default: a = 32'h0000517D;
            endcase
            return a;
        end
    endfunction

    // wheel color {r,g,b}
    function automatic logic [23:0] wheel_color(input logic [5:0] k);
        logic [23:0] c;
        begin
            case (k)
                6'd0: c = {8'd255, 8'd0, 8'd0};
                6'd1: c = {8'd255, 8'd17, 8'd0};
                6'd2: c = {8'd255, 8'd34, 8'd0};
                6'd3: c = {8'd255, 8'd51, 8'd0};
                6'd4: c = {8'd255, 8'd68, 8'd0};
                6'd5: c = {8'd255, 8'd85, 8'd0};
                6'd6: c = {8'd255, 8'd102, 8'd0};
                6'd7: c = {8'd255, 8'd119, 8'd0};
                6'd8: c = {8'd255, 8'd136, 8'd0};
                6'd9: c = {8'd255, 8'd153, 8'd0};
                6'd10: c = {8'd255, 8'd170, 8'd0};
                6'd11: c = {8'd255, 8'd187, 8'd0};
                6'd12: c = {8'd255, 8'd204, 8'd0};
                6'd13: c = {8'd255, 8'd221, 8'd0};
                6'd14: c = {8'd255, 8'd238, 8'd0};
                6'd15: c = {8'd255, 8'd255, 8'd0};
                6'd16: c = {8'd213, 8'd255, 8'd0};
                6'd17: c = {8'd170, 8'd255, 8'd0};
                6'd18: c = {8'd128, 8'd255, 8'd0};
                6'd19: c = {8'd85, 8'd255, 8'd0};
                6'd20: c = {8'd43, 8'd255, 8'd0};
                6'd21: c = {8'd0, 8'd255, 8'd0};
                6'd22: c = {8'd0, 8'd255, 8'd63};
                6'd23: c = {8'd0, 8'd255, 8'd127};
                6'd24: c = {8'd0, 8'd255, 8'd191};
                6'd25: c = {8'd0, 8'd255, 8'd255};
                6'd26: c = {8'd0, 8'd232, 8'd255};
                6'd27: c = {8'd0, 8'd209, 8'd255};
                6'd28: c = {8'd0, 8'd186, 8'd255};
                6'd29: c = {8'd0, 8'd163, 8'd255};
                6'd30: c = {8'd0, 8'd140, 8'd255};
                6'd31: c = {8'd0, 8'd116, 8'd255};
                6'd32: c = {8'd0, 8'd93, 8'd255};
                6'd33: c = {8'd0, 8'd70, 8'd255};
                6'd34: c = {8'd0, 8'd47, 8'd255};
                6'd35: c = {8'd0, 8'd24, 8'd255};
                6'd36: c = {8'd0, 8'd0, 8'd255};
                6'd37: c = {8'd19, 8'd0, 8'd255};
                6'd38: c = {8'd39, 8'd0, 8'd255};
                6'd39: c = {8'd58, 8'd0, 8'd255};
                6'd40: c = {8'd78, 8'd0, 8'd255};
                6'd41: c = {8'd98, 8'd0, 8'd255};
                6'd42: c = {8'd117, 8'd0, 8'd255};
                6'd43: c = {8'd137, 8'd0, 8'd255};
                6'd44: c = {8'd156, 8'd0, 8'd255};
                6'd45: c = {8'd176, 8'd0, 8'd255};
                6'd46: c = {8'd196, 8'd0, 8'd255};
                6'd47: c = {8'd215, 8'd0, 8'd255};
                6'd48: c = {8'd235, 8'd0, 8'd255};
                6'd49: c = {8'd255, 8'd0, 8'd255};
                6'd50: c = {8'd255, 8'd0, 8'd213};
                6'd51: c = {8'd255, 8'd0, 8'd170};
                6'd52: c = {8'd255, 8'd0, 8'd128};
                6'd53: c = {8'd255, 8'd0, 8'd85};
                6'd54: c = {8'd255, 8'd0, 8'd43};
                default: c = 24'd0;
            endcase
            return c;
        end
    endfunction
endpackage
`default_nettype wire

>>> src/ofcw_cordic.sv
`default_nettype none
// Pipelined vectoring CORDIC: one stage per iteration, side data rides along.
module ofcw_cordic #(
    parameter int SIDE_W = 34
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic signed [15:0] in_u,
    input  wire logic signed [15:0] in_v,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [31:0]            out_z,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int N = ofcw_pkg::CORDIC_STEPS;

    // |x| grows to about 2.33*2^31 (gain times sqrt 2), y stays inside 34 bits
    logic signed [33:0] x_reg [0:N];
    logic signed [33:0] y_reg [0:N];
    logic [31:0]        z_reg [0:N];
    logic               byp_reg [0:N];
    logic [SIDE_W-1:0]  side_reg [0:N];
    logic [N:0]         vld_reg;

    logic signed [33:0] x_next, y_next;
    logic [31:0]        z_next;

    always_comb begin
        x_next = {{2{in_u[15]}}, in_u, 16'd0};
        y_next = {{2{in_v[15]}}, in_v, 16'd0};
        z_next = 32'd0;
        if (in_u[15]) begin
            x_next = -x_next;
            y_next = -y_next;
            z_next = 32'h80000000;
        end
        if (in_v == 16'sd0) begin
            z_next = in_u[15] ? 32'h80000000 : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            byp_reg[0]  <= (in_v == 16'sd0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [33:0] dx, dy;
        logic [31:0]        a;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign a  = ofcw_pkg::atan_turn(4'(i));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                byp_reg[i+1]  <= byp_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (byp_reg[i]) begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end else if (y_reg[i] > 34'sd0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + a;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - a;
                end
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_z     = z_reg[N];
    assign out_side  = side_reg[N];
endmodule
`default_nettype wire

>>> src/ofcw_isqrt.sv
`default_nettype none
// Pipelined restoring square root, one result bit per stage (17 result bits).
module ofcw_isqrt (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [33:0] in_n,
    output logic [16:0]      out_r
);
    localparam int STEPS = 17;

    logic [33:0] rem_reg [0:STEPS];
    logic [16:0] root_reg [0:STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_n;
            root_reg[0] <= 17'd0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_bit
        localparam int B = STEPS - 1 - i;
        logic [35:0] trial;
        assign trial = ({19'd0, root_reg[i]} << (B + 1)) + (36'd1 << (2 * B));
        always_ff @(posedge aclk) begin
            if (en) begin
                if ({2'b00, rem_reg[i]} >= trial) begin
                    rem_reg[i+1]  <= rem_reg[i] - trial[33:0];
                    root_reg[i+1] <= root_reg[i] | (17'd1 << B);
                end else begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i];
                end
            end
        end
    end

    assign out_r = root_reg[STEPS];
endmodule
`default_nettype wire

>>> src/ofcw_shade.sv
`default_nettype none
// Wheel lookup, blend and fade/dim; four register stages.
module ofcw_shade (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_z,
    input  wire logic        in_inside,
    input  wire logic [16:0] in_rad,
    output logic             out_valid,
    output logic [23:0]      out_rgb
);
    // stage A: position
    logic        va_reg, ia_reg;
    logic [37:0] pos_reg;
    // stage B: lookup; the radius arrives one stage behind the phase
    logic        vb_reg, ib_reg;
    logic [16:0] rb_reg, fb_reg;
    logic [23:0] c0_reg, c1_reg;
    // stage C: blend
    logic        vc_reg, ic_reg;
    logic [16:0] rc_reg;
    logic [23:0] cb_reg [0:2];
    // stage D: output
    logic        vd_reg;
    logic [7:0]  o_reg [0:2];

    logic [5:0] k0, k1;
    assign k0 = (pos_reg[37:32] >= 6'(ofcw_pkg::WHEEL_SIZE))
              ? 6'(ofcw_pkg::WHEEL_SIZE - 1) : pos_reg[37:32];
    assign k1 = (k0 == 6'(ofcw_pkg::WHEEL_SIZE - 1)) ? 6'd0 : k0 + 6'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
        if (en) begin
            pos_reg <= 38'(in_z) * 38'd54;
            ia_reg  <= in_inside;
            fb_reg  <= {1'b0, pos_reg[31:16]};
            c0_reg  <= ofcw_pkg::wheel_color(k0);
            c1_reg  <= ofcw_pkg::wheel_color(k1);
            ib_reg  <= ia_reg;
            rb_reg  <= in_rad;
            ic_reg  <= ib_reg;
            rc_reg  <= rb_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [7:0]  a0, a1;
        logic [23:0] d;
        logic [41:0] prod;
        logic [42:0] fade;
        logic [25:0] dim;
        assign a0   = c0_reg[8*c +: 8];
        assign a1   = c1_reg[8*c +: 8];
        assign d    = 24'd16711680 - cb_reg[c];
        assign prod = 42'(rc_reg) * 42'(d);
        assign fade = (43'd255 << 32) - 43'(prod);
        assign dim  = 26'(cb_reg[c]) * 26'd3;
        always_ff @(posedge aclk) begin
            if (en) begin
                cb_reg[c] <= 24'(25'(a0) * (25'd65536 - 25'(fb_reg))
                                 + 25'(a1) * 25'(fb_reg));
                o_reg[c]  <= ic_reg ? fade[39:32] : dim[25:18];
            end
        end
        assign out_rgb[8*c +: 8] = o_reg[c];
    end

    assign out_valid = vd_reg;
endmodule
`default_nettype wire

>>> src/optical_flow_color_wheel_top.sv
`default_nettype none
// Channel | ports                              | direction
// input   | s_valid s_ready s_flow_u s_flow_v  | in
// result  | m_valid m_ready m_red m_green m_blue | out
// One pixel per clock while the skid slot is free (1 setup, 16 CORDIC
// stages, 4 shading stages, 1 output register). The square root runs in parallel
// with the CORDIC, one bit per stage, and joins at the second shading stage.
// Reset (aresetn, synchronous) clears the valid bits only. The pipeline
// freezes as a whole while the skid slot is full; the skid slot catches
// the item in flight when the output stalls, so no transaction is lost.
module optical_flow_color_wheel_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [15:0] s_flow_u,
    input  wire logic signed [15:0] s_flow_v,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_red,
    output logic [7:0]             m_green,
    output logic [7:0]             m_blue
);
    localparam int SIDE_W = 1;

    logic        out_full_reg, skid_full_reg;
    logic [23:0] out_rgb_reg, skid_rgb_reg;
    logic        en;
    logic        p_valid;
    logic [23:0] p_rgb;

    // pipeline moves whenever the skid slot is free
    assign en      = !skid_full_reg;
    assign s_ready = en;

    // squared magnitude and unit-circle test
    logic [31:0] sq;
    logic        in_unit;
    logic [33:0] sq_scaled;
    assign sq = 32'($signed(s_flow_u) * $signed(s_flow_u))
              + 32'($signed(s_flow_v) * $signed(s_flow_v));
    assign in_unit   = {1'b0, sq} <= (33'd1 << (2 * FRAC_BITS));
    assign sq_scaled = in_unit ? (34'(sq) << (32 - 2 * FRAC_BITS)) : 34'd0;

    logic        c_valid;
    logic [31:0] c_z;
    logic [SIDE_W-1:0] c_side;
    logic [16:0] rad;

    ofcw_cordic #(.SIDE_W(SIDE_W)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_u(s_flow_u), .in_v(s_flow_v),
        .in_side(in_unit),
        .out_valid(c_valid), .out_z(c_z), .out_side(c_side)
    );

    ofcw_isqrt u_isqrt (
        .aclk(aclk), .en(en), .in_n(sq_scaled), .out_r(rad)
    );

    ofcw_shade u_shade (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c_valid), .in_z(c_z), .in_inside(c_side[0]),
        .in_rad(rad),
        .out_valid(p_valid), .out_rgb(p_rgb)
    );

    // output register plus skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            if (!out_full_reg || m_ready) begin
                if (skid_full_reg) begin
                    out_full_reg  <= 1'b1;
                    out_rgb_reg   <= skid_rgb_reg;
                    skid_full_reg <= 1'b0;
                end else begin
                    out_full_reg <= p_valid;
                    out_rgb_reg  <= p_rgb;
                end
            end else if (en && p_valid) begin
                skid_full_reg <= 1'b1;
                skid_rgb_reg  <= p_rgb;
            end
        end
    end

    assign m_valid = out_full_reg;
    assign m_blue  = out_rgb_reg[7:0];
    assign m_green = out_rgb_reg[15:8];
    assign m_red   = out_rgb_reg[23:16];

`ifndef SYNTHESIS
    a_skid_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(out_full_reg && !m_ready))
        else $error("skid filled without stall");
    a_ready_follows_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !skid_full_reg)
        else $error("ready mismatch");
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_full_reg)
        else $error("skid full with empty output");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

class pixel_scoreboard;
    logic [23:0] pending_rgb[$];

    static function logic [31:0] flow_phase(logic signed [15:0] u, logic signed [15:0] v);
        longint x, y, dx, dy;
        logic [31:0] z;
        if (v == 0) return (u < 0) ? 32'h80000000 : 32'h0;
        x = longint'(u) * 65536;
        y = longint'(v) * 65536;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += ofcw_pkg::atan_turn(i[3:0]);
            end else begin
                x -= dx;
                y += dy;
                z -= ofcw_pkg::atan_turn(i[3:0]);
            end
        end
        return z;
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    static function logic [23:0] shade(logic signed [15:0] u, logic signed [15:0] v);
        logic [63:0] pos, k0, k1, f, sq, rad, c0, c1, cb, d, val;
        logic [23:0] e0, e1, rgb;
        bit          within_unit;
        pos = 64'(flow_phase(u, v)) * 64'd54;
        k0 = pos >> 32;
        f = (pos & 64'hFFFFFFFF) >> 16;
        k1 = k0 + 1;
        if (k0 >= 55) k0 = 54;
        if (k1 >= 55) k1 = 0;
        sq = 64'(longint'(u) * u + longint'(v) * v);
        within_unit = sq <= (64'd1 << 24);
        rad = within_unit ? int_sqrt(sq << 8) : 0;
        e0 = ofcw_pkg::wheel_color(k0[5:0]);
        e1 = ofcw_pkg::wheel_color(k1[5:0]);
        for (int ch = 0; ch < 3; ch++) begin
            c0 = e0[23-8*ch -: 8];
            c1 = e1[23-8*ch -: 8];
            cb = c0 * (65536 - f) + c1 * f;
            if (within_unit) begin
                d = 64'd255 * 65536 - cb;
                val = ((64'd255 << 32) - rad * d) >> 32;
            end else begin
                val = (cb * 3) >> 18;
            end
            rgb[23-8*ch -: 8] = val[7:0];
        end
        return rgb;
    endfunction

    function void note_flow(logic signed [15:0] u, logic signed [15:0] v);
        pending_rgb.push_back(shade(u, v));
    endfunction

    function string check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [23:0] e;
        if (pending_rgb.size() == 0) return "pixel with no transaction pending";
        e = pending_rgb.pop_front();
        if ({r, g, b} !== e)
            return $sformatf("pixel got %0d,%0d,%0d exp %0d,%0d,%0d",
                             r, g, b, e[23:16], e[15:8], e[7:0]);
        return "";
    endfunction
endclass

module testbench;
    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [15:0] s_flow_u = 0;
    logic signed [15:0] s_flow_v = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [7:0]         m_red, m_green, m_blue;

    pixel_scoreboard sb = new();
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  sink_hold = 0;
    bit  no_idle = 0;

    optical_flow_color_wheel_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_flow_u(s_flow_u), .s_flow_v(s_flow_v),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    task automatic report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // one transaction; valid stays up across back-to-back items
    task automatic send_flow(logic signed [15:0] u, logic signed [15:0] v);
        while (!no_idle && $urandom_range(99) < 31) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid  <= 1;
        s_flow_u <= u;
        s_flow_v <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        string msg;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_flow(s_flow_u, s_flow_v);
            if (m_valid && m_ready) begin
                msg = sb.check_pixel(m_red, m_green, m_blue);
                if (msg != "") report(msg);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles > 5000) begin
                $display("[optical_flow_color_wheel_top] ERROR");
                $finish;
            end
        end
    end

    always @(negedge aclk)
        m_ready <= !sink_hold && (no_idle || $urandom_range(99) >= 31);

    initial begin
        repeat (300) @(negedge aclk);
        sink_hold = 1;
        repeat (200) @(negedge aclk);
        sink_hold = 0;
    end

    function automatic logic signed [15:0] rand_flow(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(8192)) - 4096);
            2: return 16'(int'($urandom_range(16)) - 8);
            default: return 0;
        endcase
    endfunction

    initial begin
        logic signed [15:0] corner[8] = '{16'sh7FFF, 16'sh8000, 0, 1, -1,
                                         16'sh1000, -16'sh1000, 16'sh0B50};
        repeat (4) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        foreach (corner[i]) send_flow(corner[i], 0);
        foreach (corner[i]) send_flow(0, corner[i]);
        send_flow(16'sh0B50, 16'sh0B50);
        send_flow(-16'sh0B50, 16'sh0B50);
        send_flow(16'sh7FFF, 16'sh7FFF);
        send_flow(16'sh8000, 16'sh8000);
        send_flow(-1, 1);
        for (int n = 0; n < 1600; n++) begin
            no_idle = (n >= 800 && n < 1000);
            send_flow(rand_flow($urandom_range(3)), rand_flow($urandom_range(3)));
        end
        no_idle = 0;
        s_valid <= 0;
        while (sb.pending_rgb.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (errors == 0 && sb.pending_rgb.size() == 0)
            $display("[optical_flow_color_wheel_top] OK");
        else
            $display("[optical_flow_color_wheel_top] ERROR");
        $finish;
    end
endmodule
